>>> hw/rtl/esl_pkg.sv
// Shared types, widths and constants of the encoder speed and length meter.
// Used by esl_ctrl, esl_dp and encoder_speed_and_length_meter_core.
// No dependencies.
package esl_pkg;

    // Default fixed point formats.
    localparam int VEL_FRAC_DEF = 16;
    localparam int LEN_FRAC_DEF = 24;

    // Field and register widths.
    localparam int TS_W       = 32;
    localparam int PERIOD_W   = 32;
    localparam int VEL_W      = 40;
    localparam int LEN_W      = 48;
    localparam int PPR_W      = 16;
    localparam int RADIUS_W   = 16;
    localparam int UNIT_W     = 2;
    localparam int INIT_LEN_W = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Datapath widths: divisor, numerator, serial product and quotient.
    localparam int DEN_W  = PPR_W + PERIOD_W;
    localparam int NUM_W  = 64;
    localparam int PROD_W = 90;
    localparam int QUO_W  = LEN_W;

    // Quotient bits produced for the length step and for the velocity.
    localparam int DIV_STEP_BITS = QUO_W;
    localparam int DIV_VEL_BITS  = VEL_W;
    localparam int CNT_W         = $clog2(DIV_STEP_BITS + 1);

    // 2*pi in Q4.60, truncated, and the same scaled by 1000 for mm to m.
    localparam int TWO_PI_FRAC = 60;
    localparam logic [NUM_W-1:0]  TWO_PI_Q60   = 64'h6487_ED51_10B4_611A;
    localparam logic [PROD_W-1:0] TWO_PI_K1000 = PROD_W'(TWO_PI_Q60) * PROD_W'(1000);

    // Saturation limits.
    localparam logic [VEL_W-1:0]        VEL_SAT = {VEL_W{1'b1}};
    localparam logic [QUO_W-1:0]        STEP_SAT = {QUO_W{1'b1}};
    localparam logic signed [LEN_W-1:0] LEN_MAX = {1'b0, {(LEN_W-1){1'b1}}};
    localparam logic signed [LEN_W-1:0] LEN_MIN = {1'b1, {(LEN_W-1){1'b0}}};

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_PPR      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_LEN = 2'd3;

    // Velocity unit codes.
    localparam logic [UNIT_W-1:0] UNIT_RAD = 2'd0;
    localparam logic [UNIT_W-1:0] UNIT_DEG = 2'd1;
    localparam logic [UNIT_W-1:0] UNIT_RPM = 2'd2;
    localparam logic [UNIT_W-1:0] UNIT_MS  = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [PPR_W-1:0]    PPR_RST    = 16'd1024;
    localparam logic [RADIUS_W-1:0] RADIUS_RST = 16'd50;

    // Input and result words.
    typedef struct packed {
        logic [TS_W-1:0] timestamp_us;
        logic            dir_level;
    } t_esl_in;

    typedef struct packed {
        logic [PERIOD_W-1:0]     period_us;
        logic [VEL_W-1:0]        velocity;
        logic signed [LEN_W-1:0] cable_length;
    } t_esl_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic den_load;
        logic mul_load;
        logic mul_ms;
        logic mul_step;
        logic div_load;
        logic div_vel;
        logic div_step;
        logic step_store;
        logic len_update;
        logic out_load;
    } t_esl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mul_done;
        logic div_sat;
        logic den_zero;
        logic ppr_zero;
        logic step_ok;
        logic unit_ms;
    } t_esl_sts;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DEN,
        ST_SMUL,
        ST_SDIV,
        ST_LEN,
        ST_VSEL,
        ST_VMUL,
        ST_VDIV,
        ST_OUT
    } t_esl_state;

    // Takes a wide constant product down to a numerator by a right shift.
    function automatic logic [NUM_W-1:0] f_scaled(input logic [PROD_W-1:0] p, input int sh);
        return NUM_W'(p >> sh);
    endfunction

endpackage

>>> hw/rtl/encoder_speed_and_length_meter_core.sv
// Top level of the encoder speed and length meter: controller and datapath.
// Depends on esl_pkg, esl_ctrl and esl_dp.
//
// Each input word is one channel-A pulse (microsecond timestamp, channel-B
// level). The block returns the period since the previous pulse, the speed
// in the unit set by velocity_unit (Q.VEL_FRAC_BITS, saturating, zero for a
// zero period) and the cable length (signed Q.LEN_FRAC_BITS meters). It takes
// one word at a time; how long a word occupies the block is set by the
// bit-serial restoring divider that yields one of the 40 velocity bits per
// cycle. In the m/s unit a shift-and-add multiply by the drum radius runs
// first, stepping through the radius bits up to its highest set bit. After
// reset or a write of pulses_per_rev or drum_radius_mm the first word also
// recomputes the length step: a multiply of the same kind and a 48-bit
// division. Results wait in an output register, so the next word is taken
// while a result is still pending. There is no clearing pass after reset.
module encoder_speed_and_length_meter_core #(
    parameter int VEL_FRAC_BITS = esl_pkg::VEL_FRAC_DEF,
    parameter int LEN_FRAC_BITS = esl_pkg::LEN_FRAC_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [esl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [esl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  esl_pkg::t_esl_in               i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output esl_pkg::t_esl_out              o_out_word
);
    import esl_pkg::*;

    t_esl_cmd cmd;
    t_esl_sts sts;

    // Sequencer.
    esl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Arithmetic and storage.
    esl_dp #(
        .VEL_FRAC_BITS (VEL_FRAC_BITS),
        .LEN_FRAC_BITS (LEN_FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_word  (i_in_word),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_word (o_out_word)
    );

endmodule

>>> hw/rtl/esl_ctrl.sv
// Controller of the encoder speed and length meter: sequences the datapath
// through capture, length step, velocity division and result hand-off.
// Depends on esl_pkg.
module esl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  esl_pkg::t_esl_sts i_sts,
    output esl_pkg::t_esl_cmd o_cmd
);
    import esl_pkg::*;

    t_esl_state       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid;
    t_esl_cmd         cmd;

    // State register and division bit counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        cmd     = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = ST_DEN;
                end
            end
            ST_DEN: begin
                // The length step is reused while the geometry is unchanged.
                cmd.den_load = 1'b1;
                if (i_sts.ppr_zero) begin
                    n_state = ST_VSEL;
                end else if (i_sts.step_ok) begin
                    n_state = ST_LEN;
                end else begin
                    cmd.mul_load = 1'b1;
                    n_state      = ST_SMUL;
                end
            end
            ST_SMUL: begin
                if (i_sts.mul_done) begin
                    cmd.div_load = 1'b1;
                    n_cnt        = CNT_W'(DIV_STEP_BITS);
                    n_state      = ST_SDIV;
                end else begin
                    cmd.mul_step = 1'b1;
                end
            end
            ST_SDIV: begin
                if (i_sts.div_sat || r_cnt == '0) begin
                    cmd.step_store = 1'b1;
                    n_state        = ST_LEN;
                end else begin
                    cmd.div_step = 1'b1;
                    n_cnt        = r_cnt - 1'b1;
                end
            end
            ST_LEN: begin
                cmd.len_update = 1'b1;
                n_state        = ST_VSEL;
            end
            ST_VSEL: begin
                if (i_sts.den_zero) begin
                    n_state = ST_OUT;
                end else if (i_sts.unit_ms) begin
                    cmd.mul_load = 1'b1;
                    cmd.mul_ms   = 1'b1;
                    n_state      = ST_VMUL;
                end else begin
                    cmd.div_load = 1'b1;
                    cmd.div_vel  = 1'b1;
                    n_cnt        = CNT_W'(DIV_VEL_BITS);
                    n_state      = ST_VDIV;
                end
            end
            ST_VMUL: begin
                if (i_sts.mul_done) begin
                    cmd.div_load = 1'b1;
                    cmd.div_vel  = 1'b1;
                    n_cnt        = CNT_W'(DIV_VEL_BITS);
                    n_state      = ST_VDIV;
                end else begin
                    cmd.mul_step = 1'b1;
                end
            end
            ST_VDIV: begin
                if (i_sts.div_sat || r_cnt == '0) begin
                    n_state = ST_OUT;
                end else begin
                    cmd.div_step = 1'b1;
                    n_cnt        = r_cnt - 1'b1;
                end
            end
            ST_OUT: begin
                // Wait until the output register is free or being emptied.
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output word valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    // A word in work blocks the input until its result is loaded into the output register.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted again while a word is in work");

    // The velocity division never runs more bits than the result holds.
    a_vel_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_VDIV) |-> (r_cnt <= CNT_W'(DIV_VEL_BITS)))
        else $error("velocity division counter out of range");

    // A result only appears through the hand-off state.
    a_out_from_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_OUT))
        else $error("result presented outside the hand-off state");

endmodule

>>> hw/rtl/esl_dp.sv
// Datapath of the encoder speed and length meter: configuration registers,
// period capture, bit-serial multiplier, restoring divider and length store.
// Depends on esl_pkg.
module esl_dp #(
    parameter int VEL_FRAC_BITS = esl_pkg::VEL_FRAC_DEF,
    parameter int LEN_FRAC_BITS = esl_pkg::LEN_FRAC_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [esl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [esl_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  esl_pkg::t_esl_in                 i_in_word,
    input  esl_pkg::t_esl_cmd                i_cmd,
    output esl_pkg::t_esl_sts                o_sts,
    output esl_pkg::t_esl_out                o_out_word
);
    import esl_pkg::*;

    // Shift that brings a Q.60 product to the wanted fraction.
    localparam int VEL_SH  = TWO_PI_FRAC - VEL_FRAC_BITS;
    localparam int STEP_SH = TWO_PI_FRAC - LEN_FRAC_BITS;
    localparam int LENX_W  = LEN_W + 2;
    localparam int LDX_W   = 64;

    // Numerators of the fixed velocity units.
    localparam logic [NUM_W-1:0] NUM_RAD =
        f_scaled(PROD_W'(TWO_PI_Q60) * PROD_W'(1_000_000), VEL_SH);
    localparam logic [NUM_W-1:0] NUM_DEG = NUM_W'(64'd360_000_000 << VEL_FRAC_BITS);
    localparam logic [NUM_W-1:0] NUM_RPM = NUM_W'(64'd60_000_000 << VEL_FRAC_BITS);

    // Configuration and state.
    logic [PPR_W-1:0]        r_ppr;
    logic [RADIUS_W-1:0]     r_radius;
    logic [UNIT_W-1:0]       r_unit;
    logic [TS_W-1:0]         r_last_time;
    logic signed [LEN_W-1:0] r_len;
    logic                    r_step_ok;

    // Work registers.
    logic                    r_dir;
    logic [PERIOD_W-1:0]     r_period;
    logic [DEN_W-1:0]        r_den;
    logic [PROD_W-1:0]       r_mcand;
    logic [RADIUS_W-1:0]     r_mplier;
    logic [PROD_W-1:0]       r_prod;
    logic [QUO_W-1:0]        r_num;
    logic [DEN_W-1:0]        r_rem;
    logic [DEN_W-1:0]        r_dvs;
    logic [QUO_W-1:0]        r_quo;
    logic                    r_div_sat;
    logic [QUO_W-1:0]        r_step;
    t_esl_out                r_out_word;

    logic [NUM_W-1:0]        div_num;
    logic [NUM_W-1:0]        div_hi;
    logic [DEN_W-1:0]        div_dvs;
    logic                    div_sat_now;
    logic [DEN_W:0]          trial;
    logic                    take;
    logic signed [LENX_W-1:0] len_x, step_x, len_sum;
    logic signed [LEN_W-1:0] n_len_step;
    logic signed [LDX_W-1:0] ld_x;
    logic signed [LEN_W-1:0] n_len_load;

    // Divider set-up: numerator, divisor and early saturation test.
    always_comb begin
        if (i_cmd.div_vel) begin
            div_dvs = r_den;
            case (r_unit)
                UNIT_RAD: div_num = NUM_RAD;
                UNIT_DEG: div_num = NUM_DEG;
                UNIT_RPM: div_num = NUM_RPM;
                default:  div_num = NUM_W'(r_prod >> VEL_SH);
            endcase
            div_hi = div_num >> DIV_VEL_BITS;
        end else begin
            div_dvs = DEN_W'(r_ppr) * DEN_W'(1000);
            div_num = NUM_W'(r_prod >> STEP_SH);
            div_hi  = div_num >> DIV_STEP_BITS;
        end
        // The quotient overflows its width exactly when the high part reaches the divisor.
        div_sat_now = (div_hi >= NUM_W'(div_dvs));
    end

    // One restoring division step.
    always_comb begin
        trial = {r_rem, r_num[QUO_W-1]};
        take  = (trial >= {1'b0, r_dvs});
    end

    // Length update by one step, saturated.
    always_comb begin
        len_x  = LENX_W'(r_len);
        step_x = signed'(LENX_W'(r_step));
        len_sum = r_dir ? (len_x + step_x) : (len_x - step_x);
        if (len_sum > LENX_W'(LEN_MAX)) begin
            n_len_step = LEN_MAX;
        end else if (len_sum < LENX_W'(LEN_MIN)) begin
            n_len_step = LEN_MIN;
        end else begin
            n_len_step = LEN_W'(len_sum);
        end
    end

    // Whole meters written by configuration, saturated to the length format.
    always_comb begin
        ld_x = LDX_W'(signed'(i_cfg_data[INIT_LEN_W-1:0])) <<< LEN_FRAC_BITS;
        if (ld_x > LDX_W'(LEN_MAX)) begin
            n_len_load = LEN_MAX;
        end else if (ld_x < LDX_W'(LEN_MIN)) begin
            n_len_load = LEN_MIN;
        end else begin
            n_len_load = LEN_W'(ld_x);
        end
    end

    // Configuration registers, last timestamp, length and step-valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppr       <= PPR_RST;
            r_radius    <= RADIUS_RST;
            r_unit      <= UNIT_RAD;
            r_last_time <= '0;
            r_len       <= '0;
            r_step_ok   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PPR: begin
                        r_ppr     <= i_cfg_data[PPR_W-1:0];
                        r_step_ok <= 1'b0;
                    end
                    CFG_RADIUS: begin
                        r_radius  <= i_cfg_data[RADIUS_W-1:0];
                        r_step_ok <= 1'b0;
                    end
                    CFG_UNIT: begin
                        r_unit <= i_cfg_data[UNIT_W-1:0];
                    end
                    CFG_INIT_LEN: begin
                        r_len <= n_len_load;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.capture) begin
                r_last_time <= i_in_word.timestamp_us;
            end
            if (i_cmd.len_update) begin
                r_len <= n_len_step;
            end
            if (i_cmd.step_store) begin
                r_step_ok <= 1'b1;
            end
        end
    end

    // Work registers: capture, multiplier, divider and result word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_dir    <= i_in_word.dir_level;
            r_period <= i_in_word.timestamp_us - r_last_time;
        end
        if (i_cmd.den_load) begin
            r_den <= DEN_W'(r_ppr) * DEN_W'(r_period);
        end
        // Shift-and-add multiply of a 2*pi constant by the radius.
        if (i_cmd.mul_load) begin
            r_mcand  <= i_cmd.mul_ms ? TWO_PI_K1000 : PROD_W'(TWO_PI_Q60);
            r_mplier <= r_radius;
            r_prod   <= '0;
        end else if (i_cmd.mul_step) begin
            if (r_mplier[0]) begin
                r_prod <= r_prod + r_mcand;
            end
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
        end
        // Restoring division, one quotient bit a cycle.
        if (i_cmd.div_load) begin
            r_dvs     <= div_dvs;
            r_rem     <= DEN_W'(div_hi);
            r_div_sat <= div_sat_now;
            if (i_cmd.div_vel) begin
                r_num <= QUO_W'(div_num << (DIV_STEP_BITS - DIV_VEL_BITS));
                r_quo <= div_sat_now ? QUO_W'(VEL_SAT) : '0;
            end else begin
                r_num <= QUO_W'(div_num);
                r_quo <= div_sat_now ? STEP_SAT : '0;
            end
        end else if (i_cmd.div_step) begin
            r_rem <= take ? DEN_W'(trial - {1'b0, r_dvs}) : trial[DEN_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], take};
            r_num <= r_num << 1;
        end
        if (i_cmd.step_store) begin
            r_step <= r_quo;
        end
        if (i_cmd.out_load) begin
            r_out_word.period_us    <= r_period;
            r_out_word.velocity     <= (r_den == '0) ? '0 : VEL_W'(r_quo);
            r_out_word.cable_length <= r_len;
        end
    end

    // Status to the controller.
    always_comb begin
        o_sts.mul_done = (r_mplier == '0);
        o_sts.div_sat  = r_div_sat;
        o_sts.den_zero = (r_den == '0);
        o_sts.ppr_zero = (r_ppr == '0);
        o_sts.step_ok  = r_step_ok;
        o_sts.unit_ms  = (r_unit == UNIT_MS);
    end

    assign o_out_word = r_out_word;

    // The partial remainder stays below the divisor throughout a division.
    a_rem_below_dvs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < r_dvs))
        else $error("division remainder not below divisor");

    // The length only moves by a step that has been worked out.
    a_step_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.len_update |-> r_step_ok)
        else $error("length updated with a stale step");

endmodule

>>> tb/encoder_meter_checker.sv
// Checker for the encoder speed and length meter: tracks the register writes,
// predicts the result word of every accepted pulse word and compares it.
// Depends on esl_pkg.
module encoder_meter_checker #(
    parameter int VEL_FRAC = esl_pkg::VEL_FRAC_DEF,
    parameter int LEN_FRAC = esl_pkg::LEN_FRAC_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [esl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [esl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  esl_pkg::t_esl_in               i_in_word,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  esl_pkg::t_esl_out              i_out_word,
    output int                             o_pending,
    output int                             o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import esl_pkg::*;

    localparam logic [63:0] STEP_MASK = 64'h0000_FFFF_FFFF_FFFF;

    // Mirror of the configuration and of the meter state.
    logic [PPR_W-1:0]        ppr;
    logic [RADIUS_W-1:0]     radius;
    logic [UNIT_W-1:0]       unit;
    logic [TS_W-1:0]         last_stamp;
    logic signed [LEN_W-1:0] length_acc;

    // Result words still owed by the block, oldest first.
    t_esl_out meter_results_q[$];
    t_esl_out want;
    int       mismatches = 0;

    // floor(((a * b) >> sh) / d), limited to lim; d is never zero here.
    function automatic logic [63:0] frac_div(input logic [63:0] a, input logic [63:0] b,
                                             input int sh, input logic [63:0] d,
                                             input logic [63:0] lim);
        logic [127:0] num;
        logic [127:0] quo;
        num = ({64'd0, a} * {64'd0, b}) >> sh;
        quo = num / {64'd0, d};
        return (quo > {64'd0, lim}) ? lim : quo[63:0];
    endfunction

    function automatic logic signed [LEN_W-1:0] clamp_length(input logic signed [63:0] v);
        logic signed [63:0] hi_lim;
        logic signed [63:0] lo_lim;
        hi_lim = 64'(LEN_MAX);
        lo_lim = 64'(LEN_MIN);
        if (v > hi_lim) return LEN_MAX;
        if (v < lo_lim) return LEN_MIN;
        return LEN_W'(v);
    endfunction

    // Speed in the selected unit for one period; zero when the divisor is zero.
    function automatic logic [VEL_W-1:0] speed_of(input logic [PERIOD_W-1:0] period);
        logic [63:0] den;
        logic [63:0] lim;
        den = 64'(ppr) * 64'(period);
        lim = 64'(VEL_SAT);
        if (den == 0) return '0;
        case (unit)
            UNIT_RAD: return VEL_W'(frac_div(TWO_PI_Q60, 64'd1000000, 60 - VEL_FRAC, den, lim));
            UNIT_DEG: return VEL_W'(frac_div(64'd360000000, 64'd1 << VEL_FRAC, 0, den, lim));
            UNIT_RPM: return VEL_W'(frac_div(64'd60000000, 64'd1 << VEL_FRAC, 0, den, lim));
            default: begin
                return VEL_W'(frac_div(TWO_PI_Q60, 64'(radius) * 64'd1000,
                                       60 - VEL_FRAC, den, lim));
            end
        endcase
    endfunction

    // Advances the meter by one pulse and gives the word it should return.
    task automatic predict_pulse(input t_esl_in w, output t_esl_out r);
        logic [PERIOD_W-1:0] period;
        logic [63:0]         step;
        logic signed [63:0]  acc;
        period = w.timestamp_us - last_stamp;
        last_stamp = w.timestamp_us;
        if (ppr != 0) begin
            step = frac_div(TWO_PI_Q60, 64'(radius), 60 - LEN_FRAC,
                            64'(ppr) * 64'd1000, STEP_MASK);
            acc = 64'(length_acc);
            acc = w.dir_level ? acc + $signed(step) : acc - $signed(step);
            length_acc = clamp_length(acc);
        end
        r.period_us    = period;
        r.velocity     = speed_of(period);
        r.cable_length = length_acc;
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            $display("%0t ns: %s expected %h actual %h", $time, name, exp_v, act_v);
        end
    endtask

    // Loads the whole-metre start length into the accumulator.
    task automatic load_length(input logic [INIT_LEN_W-1:0] metres);
        logic signed [INIT_LEN_W-1:0] m;
        logic signed [63:0]           v;
        m = metres;
        v = 64'(m);
        length_acc = clamp_length(v <<< LEN_FRAC);
    endtask

    // Everything is sampled at the rising edge, so the values seen are the
    // ones the block itself registers at that edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ppr        = PPR_RST;
            radius     = RADIUS_RST;
            unit       = UNIT_RAD;
            last_stamp = '0;
            length_acc = '0;
            meter_results_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PPR:      ppr = i_cfg_data[PPR_W-1:0];
                    CFG_RADIUS:   radius = i_cfg_data[RADIUS_W-1:0];
                    CFG_UNIT:     unit = i_cfg_data[UNIT_W-1:0];
                    CFG_INIT_LEN: load_length(i_cfg_data[INIT_LEN_W-1:0]);
                    default: ;
                endcase
            end
            // A result word leaving now belongs to an earlier pulse word.
            if (i_out_valid && i_out_ready) begin
                if (meter_results_q.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: result word expected none actual %h",
                             $time, i_out_word);
                end else begin
                    want = meter_results_q.pop_front();
                    check_field("period_us", 64'(want.period_us), 64'(i_out_word.period_us));
                    check_field("velocity", 64'(want.velocity), 64'(i_out_word.velocity));
                    check_field("cable_length", 64'(want.cable_length),
                                64'(i_out_word.cable_length));
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_pulse(i_in_word, want);
                meter_results_q.push_back(want);
            end
        end
        o_pending    <= meter_results_q.size();
        o_fail_count <= mismatches;
    end

endmodule

>>> tb/encoder_speed_and_length_meter_core_tb.sv
// Testbench top of the encoder speed and length meter: clock, reset, pulse
// stimulus, register writes and the verdict. Depends on esl_pkg, the meter
// core and encoder_meter_checker.
module encoder_speed_and_length_meter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import esl_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int CHUNKS       = 18;
    localparam int CHUNK_PULSES = 75;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_esl_in               i_in_word;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_esl_out              o_out_word;

    int          pending_words;
    int          fail_count;
    int          src_idle_pct = 18;
    int          sink_idle_pct = 46;
    int          cycles = 0;
    logic [31:0] stamp = '0;
    logic        dir = 1'b1;

    always #6 i_clk = ~i_clk;

    encoder_speed_and_length_meter_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    encoder_meter_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_word    (i_in_word),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_word   (o_out_word),
        .o_pending    (pending_words),
        .o_fail_count (fail_count)
    );

    // Receiver side: ready drops at random at the current stall rate.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Offers one pulse word, delta microseconds after the previous one.
    task automatic send_pulse(input logic [31:0] delta, input logic level);
        t_esl_in w;
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        stamp = stamp + delta;
        w.timestamp_us = stamp;
        w.dir_level    = level;
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Waits until every result word owed by the block has been taken.
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_words != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Spread of pulse gaps: zero, short, moderate, long and fully random.
    function automatic logic [31:0] pick_gap();
        case ($urandom_range(9))
            0:       return 32'd0;
            1, 2:    return $urandom_range(1, 16);
            3, 4, 5: return $urandom_range(17, 5000);
            6, 7:    return $urandom_range(5001, 2000000);
            default: return $urandom();
        endcase
    endfunction

    // New register settings between chunks; upper data bits are noise.
    task automatic shuffle_config(input bit write_all);
        logic [15:0] val;
        if (write_all || $urandom_range(1)) begin
            case ($urandom_range(11))
                0:          val = 16'd0;
                1, 2:       val = 16'd1;
                3, 4:       val = 16'($urandom_range(2, 16));
                5:          val = 16'hFFFF;
                default:    val = 16'($urandom_range(1, 65535));
            endcase
            write_reg(CFG_PPR, {8'($urandom()), val});
        end
        if (write_all || $urandom_range(1)) begin
            case ($urandom_range(7))
                0:       val = 16'd0;
                1:       val = 16'hFFFF;
                2:       val = 16'd1;
                default: val = 16'($urandom_range(1, 65535));
            endcase
            write_reg(CFG_RADIUS, {8'($urandom()), val});
        end
        if (write_all || $urandom_range(1)) begin
            write_reg(CFG_UNIT, CFG_DATA_W'($urandom()));
        end
        if (write_all || $urandom_range(2) == 0) begin
            case ($urandom_range(5))
                0:       write_reg(CFG_INIT_LEN, 24'h7FFFFF);
                1:       write_reg(CFG_INIT_LEN, 24'h800000);
                2:       write_reg(CFG_INIT_LEN, 24'h000000);
                default: write_reg(CFG_INIT_LEN, 24'($urandom()));
            endcase
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_word  = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: first pulse from time zero, a wrap of the timestamp.
        send_pulse(32'd0, 1'b1);
        send_pulse(32'd1, 1'b0);
        send_pulse(32'hFFFF_FFFE, 1'b1);
        send_pulse(32'd6, 1'b1);

        // One pulse per turn in degrees: saturated speed, zero and longest period.
        settle();
        write_reg(CFG_PPR, 24'd1);
        write_reg(CFG_UNIT, CFG_DATA_W'(UNIT_DEG));
        send_pulse(32'd1, 1'b1);
        send_pulse(32'd0, 1'b0);
        send_pulse(32'hFFFF_FFFF, 1'b1);

        settle();
        write_reg(CFG_PPR, 24'h00FFFF);
        write_reg(CFG_UNIT, CFG_DATA_W'(UNIT_RPM));
        send_pulse(32'd1, 1'b0);
        send_pulse(32'd12345, 1'b1);

        // Largest step from the top of the length range: it saturates high.
        settle();
        write_reg(CFG_PPR, 24'd1);
        write_reg(CFG_RADIUS, 24'h00FFFF);
        write_reg(CFG_UNIT, CFG_DATA_W'(UNIT_MS));
        write_reg(CFG_INIT_LEN, 24'h7FFFFF);
        send_pulse(32'd1, 1'b1);
        send_pulse(32'd3, 1'b1);
        send_pulse(32'd100, 1'b0);

        // And from the bottom: it saturates low.
        settle();
        write_reg(CFG_INIT_LEN, 24'h800000);
        send_pulse(32'd7, 1'b0);
        send_pulse(32'd2, 1'b0);

        // Zero radius: no length step and no linear speed.
        settle();
        write_reg(CFG_RADIUS, 24'd0);
        send_pulse(32'd1, 1'b1);
        send_pulse(32'd1000, 1'b0);

        // Zero pulses per turn: no speed and the length holds.
        settle();
        write_reg(CFG_PPR, 24'd0);
        write_reg(CFG_UNIT, CFG_DATA_W'(UNIT_RAD));
        send_pulse(32'd1, 1'b1);
        send_pulse(32'd0, 1'b0);

        // Random chunks, each after random register writes, in three idling phases.
        for (int c = 0; c < CHUNKS; c++) begin
            settle();
            if (c < CHUNKS / 3) begin
                src_idle_pct  = 18;
                sink_idle_pct = 46;
            end else if (c < 2 * CHUNKS / 3) begin
                src_idle_pct  = 46;
                sink_idle_pct = 18;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            shuffle_config(c == 0);
            for (int n = 0; n < CHUNK_PULSES; n++) begin
                if ($urandom_range(7) == 0) dir = ~dir;
                send_pulse(pick_gap(), dir);
            end
        end

        settle();
        repeat (60) @(posedge i_clk);
        if (fail_count == 0 && pending_words == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
